>>> sv/pcdve_pkg.sv
// ----------------------------------------------------------------------------
// pcdve_pkg
// Shared types and constants for the plane coefficient delta varint encoder.
// ----------------------------------------------------------------------------
package pcdve_pkg;

    localparam int COEF_W = 32;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int BYTE_W = 8;
    localparam int CIDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILES_ACROSS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILES_DOWN   = 2'd2;

    localparam logic [CFG_W-1:0] TILE_SIZE_RESET    = 16'd32;
    localparam logic [CFG_W-1:0] TILES_ACROSS_RESET = 16'd1;
    localparam logic [CFG_W-1:0] TILES_DOWN_RESET   = 16'd1;

    localparam logic [CIDX_W-1:0] COEF_OFFSET  = 2'd0;
    localparam logic [CIDX_W-1:0] COEF_SLOPE_X = 2'd1;
    localparam logic [CIDX_W-1:0] COEF_SLOPE_Y = 2'd2;

    localparam logic [COEF_W-1:0] VARINT_LIMIT = 32'h0000_0080;
    localparam int VARINT_SHIFT = 7;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [COEF_W-1:0] a;
        logic [COEF_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic col_zero;
        logic row_zero;
    } pos_status_t;

endpackage

>>> sv/pcdve_alu.sv
// ----------------------------------------------------------------------------
// pcdve_alu
// Shared 32-bit add/subtract unit, used for the offset step and every delta.
// ----------------------------------------------------------------------------
module pcdve_alu (
    input  pcdve_pkg::alu_req_t          req,
    output logic [pcdve_pkg::COEF_W-1:0] y
);
    import pcdve_pkg::*;

    always_comb begin
        unique case (req.op)
            ALU_ADD: y = req.a + req.b;
            ALU_SUB: y = req.a - req.b;
            default: y = req.a + req.b;
        endcase
    end

endmodule

>>> sv/pcdve_grid_pos.sv
// ----------------------------------------------------------------------------
// pcdve_grid_pos
// Row-major tile position counter with wrap at the end of the grid.
// ----------------------------------------------------------------------------
module pcdve_grid_pos (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic [pcdve_pkg::CFG_W-1:0] tiles_across,
    input  logic [pcdve_pkg::CFG_W-1:0] tiles_down,
    output pcdve_pkg::pos_status_t      status
);
    import pcdve_pkg::*;

    logic [CFG_W-1:0] column_pos_reg, column_pos_next;
    logic [CFG_W-1:0] row_pos_reg, row_pos_next;
    logic [CFG_W:0]   col_inc;
    logic [CFG_W:0]   row_inc;

    assign col_inc = {1'b0, column_pos_reg} + 1'b1;
    assign row_inc = {1'b0, row_pos_reg} + 1'b1;

    always_comb begin
        column_pos_next = column_pos_reg;
        row_pos_next    = row_pos_reg;
        if (advance) begin
            if (col_inc >= {1'b0, tiles_across}) begin
                column_pos_next = '0;
                if (row_inc >= {1'b0, tiles_down}) begin
                    row_pos_next = '0;
                end else begin
                    row_pos_next = row_inc[CFG_W-1:0];
                end
            end else begin
                column_pos_next = col_inc[CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_pos_reg <= '0;
            row_pos_reg    <= '0;
        end else begin
            column_pos_reg <= column_pos_next;
            row_pos_reg    <= row_pos_next;
        end
    end

    assign status.col_zero = (column_pos_reg == '0);
    assign status.row_zero = (row_pos_reg == '0);

endmodule

>>> sv/plane_coef_delta_varint_encoder_core.sv
// ----------------------------------------------------------------------------
// plane_coef_delta_varint_encoder_core
// Predicts tile plane coefficients from neighbors and emits zigzag varints.
// ----------------------------------------------------------------------------
// Each input request carries one tile's offset, x-slope and y-slope, with
// tiles in row-major order over the grid set by the tile registers. The
// block predicts each coefficient from the left tile, from the first tile
// of the row above, or from zero at the grid origin, and sends the wrapped
// differences as zigzag LEB128 bytes, one byte per output request, with
// m_last_of_tile set on the final byte of the tile.
// Timing: the offset step product is registered when an input request is
// accepted, S_PRED adds it to the neighbor offset, then each coefficient
// passes through S_DIFF for its difference and S_EMIT for its bytes. An
// item has 3 to 15 bytes. s_ready stays low from acceptance until the last
// byte is taken and returns the cycle after it, so a new request is not
// accepted before the previous tile has been fully sent. This pace is set
// by the single shared adder and the one-byte output shifter. A stalled
// receiver simply holds the current byte.
// Reset clears the grid position and neighbor coefficients and restores
// the register defaults (tile size 32, a one by one grid).
// ----------------------------------------------------------------------------
module plane_coef_delta_varint_encoder_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [pcdve_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcdve_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [pcdve_pkg::COEF_W-1:0] s_coef_offset,
    input  logic signed [pcdve_pkg::COEF_W-1:0] s_coef_slope_x,
    input  logic signed [pcdve_pkg::COEF_W-1:0] s_coef_slope_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [pcdve_pkg::BYTE_W-1:0]       m_out_byte,
    output logic [pcdve_pkg::CIDX_W-1:0]       m_coef_index,
    output logic                               m_last_of_tile
);
    import pcdve_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PRED,
        S_DIFF,
        S_EMIT
    } state_t;

    state_t state_reg;

    logic [CFG_W-1:0]  tile_size_reg, tiles_across_reg, tiles_down_reg;
    logic [COEF_W-1:0] left_off_reg, left_sx_reg, left_sy_reg;
    logic [COEF_W-1:0] row_off_reg, row_sx_reg, row_sy_reg;
    logic [COEF_W-1:0] cf0_reg, cf1_reg, cf2_reg;
    logic [COEF_W-1:0] base_reg, prod_reg;
    logic [COEF_W-1:0] pred0_reg, pred1_reg, pred2_reg;
    logic [COEF_W-1:0] u_reg;
    logic [CIDX_W-1:0] k_reg;

    pos_status_t       pos;
    alu_req_t          alu_req;
    logic [COEF_W-1:0] alu_y;
    logic [COEF_W-1:0] zz;
    logic [COEF_W-1:0] mul_slope, sel_base, sel_p1, sel_p2;
    logic [COEF_W+CFG_W-1:0] prod_full;
    logic [COEF_W-1:0] cur_cf, cur_pred;
    logic              accept_in, accept_out, more_bytes;

    assign s_ready    = (state_reg == S_IDLE);
    assign accept_in  = s_valid && s_ready;
    assign m_valid    = (state_reg == S_EMIT);
    assign accept_out = m_valid && m_ready;
    assign more_bytes = (u_reg >= VARINT_LIMIT);

    assign m_out_byte     = more_bytes ? {1'b1, u_reg[BYTE_W-2:0]} : u_reg[BYTE_W-1:0];
    assign m_coef_index   = k_reg;
    assign m_last_of_tile = !more_bytes && (k_reg == COEF_SLOPE_Y);

    // Predictor sources for the tile about to be accepted.
    always_comb begin
        if (!pos.col_zero) begin
            sel_base  = left_off_reg;
            mul_slope = left_sx_reg;
            sel_p1    = left_sx_reg;
            sel_p2    = left_sy_reg;
        end else if (!pos.row_zero) begin
            sel_base  = row_off_reg;
            mul_slope = row_sy_reg;
            sel_p1    = row_sx_reg;
            sel_p2    = row_sy_reg;
        end else begin
            sel_base  = '0;
            mul_slope = '0;
            sel_p1    = '0;
            sel_p2    = '0;
        end
    end

    assign prod_full = mul_slope * tile_size_reg;

    always_comb begin
        case (k_reg)
            COEF_OFFSET: begin
                cur_cf   = cf0_reg;
                cur_pred = pred0_reg;
            end
            COEF_SLOPE_X: begin
                cur_cf   = cf1_reg;
                cur_pred = pred1_reg;
            end
            default: begin
                cur_cf   = cf2_reg;
                cur_pred = pred2_reg;
            end
        endcase
    end

    always_comb begin
        if (state_reg == S_PRED) begin
            alu_req.op = ALU_ADD;
            alu_req.a  = base_reg;
            alu_req.b  = prod_reg;
        end else begin
            alu_req.op = ALU_SUB;
            alu_req.a  = cur_cf;
            alu_req.b  = cur_pred;
        end
    end

    assign zz = {alu_y[COEF_W-2:0], 1'b0} ^ {COEF_W{alu_y[COEF_W-1]}};

    pcdve_alu u_alu (
        .req (alu_req),
        .y   (alu_y)
    );

    pcdve_grid_pos u_grid_pos (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (accept_in),
        .tiles_across (tiles_across_reg),
        .tiles_down   (tiles_down_reg),
        .status       (pos)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            k_reg            <= COEF_OFFSET;
            tile_size_reg    <= TILE_SIZE_RESET;
            tiles_across_reg <= TILES_ACROSS_RESET;
            tiles_down_reg   <= TILES_DOWN_RESET;
            left_off_reg     <= '0;
            left_sx_reg      <= '0;
            left_sy_reg      <= '0;
            row_off_reg      <= '0;
            row_sx_reg       <= '0;
            row_sy_reg       <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_TILE_SIZE:    tile_size_reg    <= cfg_wdata;
                    CFG_TILES_ACROSS: tiles_across_reg <= cfg_wdata;
                    CFG_TILES_DOWN:   tiles_down_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept_in) begin
                        cf0_reg      <= s_coef_offset;
                        cf1_reg      <= s_coef_slope_x;
                        cf2_reg      <= s_coef_slope_y;
                        base_reg     <= sel_base;
                        prod_reg     <= prod_full[COEF_W-1:0];
                        pred1_reg    <= sel_p1;
                        pred2_reg    <= sel_p2;
                        left_off_reg <= s_coef_offset;
                        left_sx_reg  <= s_coef_slope_x;
                        left_sy_reg  <= s_coef_slope_y;
                        if (pos.col_zero) begin
                            row_off_reg <= s_coef_offset;
                            row_sx_reg  <= s_coef_slope_x;
                            row_sy_reg  <= s_coef_slope_y;
                        end
                        k_reg     <= COEF_OFFSET;
                        state_reg <= S_PRED;
                    end
                end
                S_PRED: begin
                    pred0_reg <= alu_y;
                    state_reg <= S_DIFF;
                end
                S_DIFF: begin
                    u_reg     <= zz;
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (accept_out) begin
                        if (more_bytes) begin
                            u_reg <= u_reg >> VARINT_SHIFT;
                        end else if (k_reg == COEF_SLOPE_Y) begin
                            state_reg <= S_IDLE;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_DIFF;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while a result byte is pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("block ready again right after accepting a tile");

    a_last_on_slope_y: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_of_tile) |-> (m_coef_index == COEF_SLOPE_Y))
        else $error("tile end flagged on a coefficient other than slope y");

    a_cont_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_byte[BYTE_W-1]) |-> !m_last_of_tile)
        else $error("continuation byte flagged as the last of the tile");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_byte)
                                   && $stable(m_coef_index)))
        else $error("pending result byte changed under a stall");

endmodule

>>> verif/plane_coef_delta_varint_encoder_checker.sv
// ----------------------------------------------------------------------------
// plane_coef_delta_varint_encoder_checker
// Predicts and checks the byte stream of the plane coefficient encoder.
// ----------------------------------------------------------------------------
// Watches the register port and both request channels of the encoder. Every
// accepted input request is run through an independent model of the tile
// predictor and the zigzag varint coder, and the bytes it should produce are
// queued. Every accepted output request is compared field by field against
// the oldest queued byte. The number of failures and the number of bytes
// still outstanding are handed to the testbench top.
// ----------------------------------------------------------------------------
module plane_coef_delta_varint_encoder_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [pcdve_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pcdve_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [pcdve_pkg::COEF_W-1:0]    s_coef_offset,
    input  logic [pcdve_pkg::COEF_W-1:0]    s_coef_slope_x,
    input  logic [pcdve_pkg::COEF_W-1:0]    s_coef_slope_y,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [pcdve_pkg::BYTE_W-1:0]    m_out_byte,
    input  logic [pcdve_pkg::CIDX_W-1:0]    m_coef_index,
    input  logic                            m_last_of_tile,
    output int                              fail_count,
    output int                              pending
);
    import pcdve_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [CIDX_W-1:0] cidx;
        logic              last;
    } varint_byte_t;

    varint_byte_t expected_bytes[$];

    logic [CFG_W-1:0]  tile_size_q    = TILE_SIZE_RESET;
    logic [CFG_W-1:0]  tiles_across_q = TILES_ACROSS_RESET;
    logic [CFG_W-1:0]  tiles_down_q   = TILES_DOWN_RESET;
    logic [COEF_W-1:0] prev_off       = '0;
    logic [COEF_W-1:0] prev_sx        = '0;
    logic [COEF_W-1:0] prev_sy        = '0;
    logic [COEF_W-1:0] row_off        = '0;
    logic [COEF_W-1:0] row_sx         = '0;
    logic [COEF_W-1:0] row_sy         = '0;
    logic [CFG_W-1:0]  next_col       = '0;
    logic [CFG_W-1:0]  next_row       = '0;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < 40) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        fail_count = fail_count + 1;
    endtask

    task automatic encode_coef(input logic [COEF_W-1:0] actual,
                               input logic [COEF_W-1:0] predicted,
                               input logic [CIDX_W-1:0] which,
                               input logic              last);
        logic [COEF_W-1:0] diff;
        logic [COEF_W-1:0] zz;
        varint_byte_t      b;
        diff = actual - predicted;
        zz   = {diff[COEF_W-2:0], 1'b0} ^ {COEF_W{diff[COEF_W-1]}};
        while (zz >= VARINT_LIMIT) begin
            b = {1'b1, zz[VARINT_SHIFT-1:0], which, 1'b0};
            expected_bytes.push_back(b);
            zz = zz >> VARINT_SHIFT;
        end
        b = {zz[BYTE_W-1:0], which, last};
        expected_bytes.push_back(b);
    endtask

    task automatic encode_tile(input logic [COEF_W-1:0] c_off,
                               input logic [COEF_W-1:0] c_sx,
                               input logic [COEF_W-1:0] c_sy);
        logic [COEF_W-1:0] p_off;
        logic [COEF_W-1:0] p_sx;
        logic [COEF_W-1:0] p_sy;
        logic [COEF_W-1:0] step_len;
        step_len = {{(COEF_W-CFG_W){1'b0}}, tile_size_q};
        if (next_col != '0) begin
            p_off = prev_off + prev_sx * step_len;
            p_sx  = prev_sx;
            p_sy  = prev_sy;
        end else if (next_row != '0) begin
            p_off = row_off + row_sy * step_len;
            p_sx  = row_sx;
            p_sy  = row_sy;
        end else begin
            p_off = '0;
            p_sx  = '0;
            p_sy  = '0;
        end
        encode_coef(c_off, p_off, COEF_OFFSET, 1'b0);
        encode_coef(c_sx, p_sx, COEF_SLOPE_X, 1'b0);
        encode_coef(c_sy, p_sy, COEF_SLOPE_Y, 1'b1);
        prev_off = c_off;
        prev_sx  = c_sx;
        prev_sy  = c_sy;
        if (next_col == '0) begin
            row_off = c_off;
            row_sx  = c_sx;
            row_sy  = c_sy;
        end
        if ({1'b0, next_col} + 17'd1 >= {1'b0, tiles_across_q}) begin
            next_col = '0;
            if ({1'b0, next_row} + 17'd1 >= {1'b0, tiles_down_q}) begin
                next_row = '0;
            end else begin
                next_row = next_row + 1'b1;
            end
        end else begin
            next_col = next_col + 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        varint_byte_t want;
        if (!aresetn) begin
            tile_size_q    = TILE_SIZE_RESET;
            tiles_across_q = TILES_ACROSS_RESET;
            tiles_down_q   = TILES_DOWN_RESET;
            prev_off       = '0;
            prev_sx        = '0;
            prev_sy        = '0;
            row_off        = '0;
            row_sx         = '0;
            row_sy         = '0;
            next_col       = '0;
            next_row       = '0;
            expected_bytes.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_TILE_SIZE:    tile_size_q    = cfg_wdata;
                    CFG_TILES_ACROSS: tiles_across_q = cfg_wdata;
                    CFG_TILES_DOWN:   tiles_down_q   = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                encode_tile(s_coef_offset, s_coef_slope_x, s_coef_slope_y);
            end
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h", m_out_byte));
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_out_byte !== want.data) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  m_out_byte, want.data));
                    end
                    if (m_coef_index !== want.cidx) begin
                        report_mismatch($sformatf("coef_index %0d, expected %0d",
                                                  m_coef_index, want.cidx));
                    end
                    if (m_last_of_tile !== want.last) begin
                        report_mismatch($sformatf("last_of_tile %0b, expected %0b",
                                                  m_last_of_tile, want.last));
                    end
                end
            end
        end
        pending = expected_bytes.size();
    end

endmodule

>>> verif/plane_coef_delta_varint_encoder_core_tb.sv
// ----------------------------------------------------------------------------
// plane_coef_delta_varint_encoder_core_tb
// Stimulus and verdict for the plane coefficient delta varint encoder.
// ----------------------------------------------------------------------------
// Drives tile requests in bursts while the output side stalls on its own
// pattern. A short directed part covers varint lengths from one to five
// bytes, the coefficient extremes, a zero-sized grid and tile size, wrapping
// offset steps, the grid end and tile counts lowered in the middle of a grid.
// Random phases then pick new register settings and send mostly planar tile
// sets, where every prediction is exact, mixed with noisy, random and extreme tiles.
// The checker beside the encoder predicts and compares every output byte.
// ----------------------------------------------------------------------------
module plane_coef_delta_varint_encoder_core_tb;
    import pcdve_pkg::*;

    localparam int RUN_LIMIT  = 50_000_000;
    localparam int TILE_GOAL  = 360;

    typedef enum int {
        RX_STREAM,
        RX_RANDOM,
        RX_SPARSE,
        RX_HOLD
    } rx_mode_t;

    logic                     aclk           = 1'b0;
    logic                     aresetn        = 1'b0;
    logic                     cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index      = CFG_TILE_SIZE;
    logic [CFG_W-1:0]         cfg_wdata      = '0;
    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic signed [COEF_W-1:0] s_coef_offset  = '0;
    logic signed [COEF_W-1:0] s_coef_slope_x = '0;
    logic signed [COEF_W-1:0] s_coef_slope_y = '0;
    logic                     m_valid;
    logic                     m_ready        = 1'b0;
    logic [BYTE_W-1:0]        m_out_byte;
    logic [CIDX_W-1:0]        m_coef_index;
    logic                     m_last_of_tile;
    int                       fail_count;
    int                       pending;

    rx_mode_t                 rx_mode        = RX_STREAM;
    int                       rx_run         = 0;
    int                       burst_left     = 0;
    int                       tiles_sent     = 0;
    logic [CFG_W-1:0]         gen_ts         = TILE_SIZE_RESET;
    logic [CFG_W-1:0]         gen_across     = TILES_ACROSS_RESET;
    logic [CFG_W-1:0]         gen_down       = TILES_DOWN_RESET;
    logic [CFG_W-1:0]         gen_col        = '0;
    logic [CFG_W-1:0]         gen_row        = '0;
    logic [COEF_W-1:0]        plane_base     = '0;
    logic [COEF_W-1:0]        plane_sx       = '0;
    logic [COEF_W-1:0]        plane_sy       = '0;

    plane_coef_delta_varint_encoder_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_coef_offset  (s_coef_offset),
        .s_coef_slope_x (s_coef_slope_x),
        .s_coef_slope_y (s_coef_slope_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_coef_index   (m_coef_index),
        .m_last_of_tile (m_last_of_tile)
    );

    plane_coef_delta_varint_encoder_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_coef_offset  (s_coef_offset),
        .s_coef_slope_x (s_coef_slope_x),
        .s_coef_slope_y (s_coef_slope_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_coef_index   (m_coef_index),
        .m_last_of_tile (m_last_of_tile),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        if (rx_run == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_run  = $urandom_range(8, 60);
        end
        rx_run = rx_run - 1;
        case (rx_mode)
            RX_STREAM: m_ready <= 1'b1;
            RX_RANDOM: m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default:   m_ready <= 1'b0;
        endcase
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        case (idx)
            CFG_TILE_SIZE:    gen_ts     = val;
            CFG_TILES_ACROSS: gen_across = val;
            CFG_TILES_DOWN:   gen_down   = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic wait_drained;
        @(negedge aclk);
        s_valid    = 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic send_tile(input logic [COEF_W-1:0] c_off,
                             input logic [COEF_W-1:0] c_sx,
                             input logic [COEF_W-1:0] c_sy);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 5);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left     = burst_left - 1;
        s_valid        = 1'b1;
        s_coef_offset  = c_off;
        s_coef_slope_x = c_sx;
        s_coef_slope_y = c_sy;
        do @(posedge aclk); while (!s_ready);
        tiles_sent = tiles_sent + 1;
        // Track the grid position so that planar tiles line up with it.
        if ({1'b0, gen_col} + 17'd1 >= {1'b0, gen_across}) begin
            gen_col = '0;
            if ({1'b0, gen_row} + 17'd1 >= {1'b0, gen_down}) begin
                gen_row = '0;
            end else begin
                gen_row = gen_row + 1'b1;
            end
        end else begin
            gen_col = gen_col + 1'b1;
        end
    endtask

    function automatic logic [COEF_W-1:0] planar_offset();
        logic [COEF_W-1:0] step_len;
        step_len = {{(COEF_W-CFG_W){1'b0}}, gen_ts};
        return plane_base + plane_sx * step_len * {{(COEF_W-CFG_W){1'b0}}, gen_col}
                          + plane_sy * step_len * {{(COEF_W-CFG_W){1'b0}}, gen_row};
    endfunction

    function automatic logic [COEF_W-1:0] extreme_coef();
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] small_delta();
        return $urandom_range(0, 400) - 200;
    endfunction

    task automatic send_planar;
        send_tile(planar_offset(), plane_sx, plane_sy);
    endtask

    task automatic send_shaped;
        logic [COEF_W-1:0] c_off;
        logic [COEF_W-1:0] c_sx;
        logic [COEF_W-1:0] c_sy;
        int kind;
        c_off = planar_offset();
        c_sx  = plane_sx;
        c_sy  = plane_sy;
        kind  = $urandom_range(0, 9);
        if (kind == 6 || kind == 7) begin
            case ($urandom_range(0, 2))
                0:       c_off = c_off + small_delta();
                1:       c_sx  = c_sx + small_delta();
                default: c_sy  = c_sy + small_delta();
            endcase
        end else if (kind == 8) begin
            c_off = $urandom;
            c_sx  = $urandom;
            c_sy  = $urandom;
        end else if (kind == 9) begin
            c_off = extreme_coef();
            c_sx  = extreme_coef();
            c_sy  = extreme_coef();
        end
        send_tile(c_off, c_sx, c_sy);
    endtask

    function automatic logic [CFG_W-1:0] pick_count(input int big_odds);
        case ($urandom_range(0, big_odds))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            default: return CFG_W'($urandom_range(2, 6));
        endcase
    endfunction

    initial begin
        int n;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // One by one grid: every tile is coded against zero.
        send_tile(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_tile(32'd63, -32'sd64, 32'd64);
        send_tile(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_tile(32'd8191, 32'd8192, -32'sd8193);
        send_tile(32'h0010_0000, 32'h0800_0000, 32'h07FF_FFFF);
        send_tile(32'd1, 32'hFFFF_FFFF, 32'd2);
        send_tile($urandom, $urandom, $urandom);
        send_tile($urandom, $urandom, $urandom);

        // Zero tile size and zero counts, which act as a one by one grid.
        wait_drained;
        write_reg(CFG_TILE_SIZE, 16'd0);
        write_reg(CFG_TILES_ACROSS, 16'd0);
        write_reg(CFG_TILES_DOWN, 16'd0);
        plane_base = $urandom;
        plane_sx   = $urandom;
        plane_sy   = $urandom;
        repeat (2) send_planar;

        // Largest tile size with wrapping steps, through the end of the grid.
        wait_drained;
        write_reg(CFG_TILE_SIZE, 16'hFFFF);
        write_reg(CFG_TILES_ACROSS, 16'd3);
        write_reg(CFG_TILES_DOWN, 16'd2);
        plane_base = 32'h1234_5678;
        plane_sx   = 32'h7FFF_FFFF;
        plane_sy   = 32'h8000_0001;
        repeat (7) send_planar;

        // Counts lowered below the current position in the middle of a grid.
        wait_drained;
        write_reg(CFG_TILE_SIZE, 16'd5);
        write_reg(CFG_TILES_ACROSS, 16'd5);
        write_reg(CFG_TILES_DOWN, 16'd3);
        plane_base = $urandom;
        plane_sx   = small_delta();
        plane_sy   = small_delta();
        repeat (3) send_planar;
        wait_drained;
        write_reg(CFG_TILES_ACROSS, 16'd2);
        repeat (2) send_planar;
        wait_drained;
        write_reg(CFG_TILES_DOWN, 16'd1);
        repeat (2) send_planar;

        while (tiles_sent < TILE_GOAL) begin
            wait_drained;
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_TILE_SIZE, 16'd0);
                1:       write_reg(CFG_TILE_SIZE, 16'd1);
                2:       write_reg(CFG_TILE_SIZE, 16'hFFFF);
                default: write_reg(CFG_TILE_SIZE, CFG_W'($urandom_range(2, 64)));
            endcase
            write_reg(CFG_TILES_ACROSS, pick_count(5));
            write_reg(CFG_TILES_DOWN, pick_count(8));
            plane_base = $urandom;
            if ($urandom_range(0, 1) == 0) begin
                plane_sx = small_delta();
                plane_sy = small_delta();
            end else begin
                plane_sx = $urandom;
                plane_sy = $urandom;
            end
            n = $urandom_range(20, 50);
            while (n > 0 && tiles_sent < TILE_GOAL) begin
                n = n - 1;
                send_shaped;
                if ($urandom_range(0, 39) == 0) begin
                    wait_drained;
                end
            end
        end

        wait_drained;
        repeat (20) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
